// ----- design/psmm_pkg.sv -----
// ----------------------------------------------------------------------------
// psmm_pkg
// shared types, codes and tables of the pointing stick motion mapper
// ----------------------------------------------------------------------------
`default_nettype none

package psmm_pkg;

   localparam int unsigned SPEED_TABLE_DEPTH = 64;
   localparam logic [7:0]  HDR_MAGIC         = 8'h50;
   localparam logic [9:0]  FACTOR_UNITY      = 10'd256;
   localparam logic [15:0] RECIP_TEN         = 16'd52429;  // 2^19 / 10, rounded up
   localparam logic [15:0] WDOG_RESET        = 16'd200;

   // configuration register indexes
   localparam logic REG_ACCEL_EN = 1'b0;
   localparam logic REG_WDOG     = 1'b1;

   // event kinds
   typedef enum logic [2:0] {
      EV_RIGHT  = 3'd0,
      EV_LEFT   = 3'd1,
      EV_DOWN   = 3'd2,
      EV_UP     = 3'd3,
      EV_REL_X  = 3'd4,
      EV_REL_Y  = 3'd5,
      EV_HWHEEL = 3'd6,
      EV_WHEEL  = 3'd7
   } ev_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_C,
      ST_FIN,
      ST_EMIT
   } state_type;

   // acceleration factor in q2.8, indexed by speed in q2.4
   localparam logic [9:0] ACCEL_TABLE [SPEED_TABLE_DEPTH] = '{
      10'd256, 10'd261, 10'd265, 10'd270, 10'd275, 10'd279, 10'd284, 10'd289,
      10'd294, 10'd300, 10'd305, 10'd310, 10'd316, 10'd321, 10'd327, 10'd333,
      10'd339, 10'd345, 10'd351, 10'd357, 10'd363, 10'd370, 10'd376, 10'd383,
      10'd390, 10'd397, 10'd404, 10'd411, 10'd418, 10'd425, 10'd433, 10'd441,
      10'd448, 10'd456, 10'd464, 10'd472, 10'd481, 10'd489, 10'd498, 10'd507,
      10'd516, 10'd525, 10'd534, 10'd544, 10'd553, 10'd563, 10'd573, 10'd583,
      10'd593, 10'd604, 10'd614, 10'd625, 10'd636, 10'd648, 10'd659, 10'd671,
      10'd682, 10'd695, 10'd707, 10'd719, 10'd732, 10'd745, 10'd758, 10'd768
   };

   // controller to datapath
   typedef struct packed {
      logic load;
      logic commit;
      logic div_start;
      logic div_step;
      logic mul_a;
      logic mul_b;
      logic mul_c;
      logic fin;
      logic advance;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic drop;
      logic mouse;
      logic accel_need;
      logic key_none;
      logic div_last;
      logic ev_final;
   } stat_type;

endpackage

`default_nettype wire

// ----- design/psmm_ctrl.sv -----
// ----------------------------------------------------------------------------
// psmm_ctrl
// sequencer: check, speed division, mouse scaling, then event emission
// ----------------------------------------------------------------------------
`default_nettype none

module psmm_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   input  psmm_pkg::stat_type  stat,
   output psmm_pkg::cmd_type   cmd
);
   import psmm_pkg::*;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_CHECK;
         ST_CHECK: begin
            if (stat.drop)            state_in = ST_IDLE;
            else if (stat.mouse)      state_in = stat.accel_need ? ST_DIV : ST_MUL_A;
            else if (stat.key_none)   state_in = ST_IDLE;
            else                      state_in = ST_EMIT;
         end
         ST_DIV:   if (stat.div_last) state_in = ST_MUL_A;
         ST_MUL_A: state_in = ST_MUL_B;
         ST_MUL_B: state_in = ST_MUL_C;
         ST_MUL_C: state_in = ST_FIN;
         ST_FIN:   state_in = ST_EMIT;
         ST_EMIT:  if (rsp_tready && stat.ev_final) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // outputs
   always_comb begin
      cmd            = '0;
      req_tready     = (state_ff == ST_IDLE);
      rsp_tvalid     = (state_ff == ST_EMIT);
      cmd.load       = (state_ff == ST_IDLE) && req_tvalid;
      cmd.commit     = (state_ff == ST_CHECK) && !stat.drop;
      cmd.div_start  = cmd.commit && stat.mouse && stat.accel_need;
      cmd.div_step   = (state_ff == ST_DIV);
      cmd.mul_a      = (state_ff == ST_MUL_A);
      cmd.mul_b      = (state_ff == ST_MUL_B);
      cmd.mul_c      = (state_ff == ST_MUL_C);
      cmd.fin        = (state_ff == ST_FIN);
      cmd.advance    = (state_ff == ST_EMIT) && rsp_tready && !stat.ev_final;
   end

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while results pending");
   a_drop_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && stat.drop) |=> (state_ff == ST_IDLE))
      else $error("dropped report did not return to idle");
   a_fin_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |=> rsp_tvalid)
      else $error("mouse result not presented");
`endif

endmodule

`default_nettype wire

// ----- design/psmm_dp.sv -----
// ----------------------------------------------------------------------------
// psmm_dp
// datapath: report registers, speed divider, scaling multipliers, event list
// ----------------------------------------------------------------------------
`default_nettype none

module psmm_dp (
   input  wire                 clock,
   input  wire                 reset,
   input  wire  [103:0]        req_tdata,
   input  wire                 csr_valid,
   input  wire                 csr_index,
   input  wire  [15:0]         csr_data,
   input  psmm_pkg::cmd_type   cmd,
   output psmm_pkg::stat_type  stat,
   output logic [15:0]         rsp_tdata,
   output logic [2:0]          rsp_tuser,
   output logic                rsp_tlast
);
   import psmm_pkg::*;

   // configuration
   logic        accel_en_ff;
   logic [15:0] wdog_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_en_ff <= 1'b1;
         wdog_ff     <= WDOG_RESET;
      end else if (csr_valid) begin
         if (csr_index == REG_ACCEL_EN) accel_en_ff <= csr_data[0];
         else                           wdog_ff     <= csr_data;
      end
   end

   // report capture
   logic [7:0]        hdr_ff;
   logic signed [7:0] dx_ff, dy_ff;
   logic              ok_ff, arrow_ff, scroll_ff, slow_ff, caps_ff;
   logic [31:0]       irq_ff, now_ff;
   logic [7:0]        bright_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hdr_ff    <= req_tdata[7:0];
         dx_ff     <= req_tdata[15:8];
         dy_ff     <= req_tdata[23:16];
         ok_ff     <= req_tdata[24];
         irq_ff    <= req_tdata[56:25];
         now_ff    <= req_tdata[88:57];
         arrow_ff  <= req_tdata[89];
         scroll_ff <= req_tdata[90];
         slow_ff   <= req_tdata[91];
         caps_ff   <= req_tdata[92];
         bright_ff <= req_tdata[100:93];
      end
   end

   // service time of the last accepted report
   logic [31:0] last_svc_ff;

   always_ff @(posedge clock) begin
      if (reset)           last_svc_ff <= '0;
      else if (cmd.commit) last_svc_ff <= now_ff;
   end

   // checks and magnitudes
   logic [31:0] wd_delay, svc_delta;
   logic [7:0]  absx, absy;
   logic [8:0]  dist_sum;
   logic        mode_arrow, mode_scroll, movx, movy;

   assign wd_delay    = now_ff - irq_ff;
   assign svc_delta   = now_ff - last_svc_ff;
   assign absx        = dx_ff[7] ? 8'(-dx_ff) : dx_ff;
   assign absy        = dy_ff[7] ? 8'(-dy_ff) : dy_ff;
   assign dist_sum    = {1'b0, absx} + {1'b0, absy};
   assign mode_arrow  = arrow_ff;
   assign mode_scroll = !arrow_ff && (scroll_ff || caps_ff);
   assign movx        = (absx >= 8'd2);
   assign movy        = (absy >= 8'd2);

   // speed divider, one quotient bit a cycle, bit 6 marks saturation
   logic [12:0] rem_ff, rem_in;
   logic [31:0] den_ff;
   logic [6:0]  quo_ff;
   logic [2:0]  cnt_ff;
   logic [37:0] trial;
   logic        fit;

   assign trial = {6'd0, den_ff} << cnt_ff;
   assign fit   = {25'd0, rem_ff} >= trial;
   assign rem_in = fit ? (rem_ff - trial[12:0]) : rem_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff <= {dist_sum, 4'd0};
         den_ff <= (svc_delta == 32'd0) ? 32'd1 : svc_delta;
         quo_ff <= '0;
         cnt_ff <= 3'd6;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[5:0], fit};
         cnt_ff <= cnt_ff - 3'd1;
      end
   end

   // acceleration factor
   logic [5:0] speed;
   logic [9:0] factor;
   logic       accel_need;

   assign accel_need = accel_en_ff && (dist_sum != 9'd0);
   assign speed      = quo_ff[6] ? 6'(SPEED_TABLE_DEPTH - 1) : quo_ff[5:0];
   assign factor     = accel_need ? ACCEL_TABLE[speed] : FACTOR_UNITY;

   // scaling chain: |d|*(30+b), times factor, divide by 10240 via reciprocal
   logic [16:0] pa_x_ff, pa_y_ff;
   logic [26:0] pb_x_ff, pb_y_ff;
   logic [30:0] pc_x_ff, pc_y_ff;
   logic [8:0]  gain;

   assign gain = 9'd30 + {1'b0, bright_ff};

   always_ff @(posedge clock) begin
      if (cmd.mul_a) begin
         pa_x_ff <= 17'(absx * gain);
         pa_y_ff <= 17'(absy * gain);
      end
      if (cmd.mul_b) begin
         pb_x_ff <= 27'(pa_x_ff * factor);
         pb_y_ff <= 27'(pa_y_ff * factor);
      end
      if (cmd.mul_c) begin
         pc_x_ff <= 31'(pb_x_ff[24:10] * RECIP_TEN);
         pc_y_ff <= 31'(pb_y_ff[24:10] * RECIP_TEN);
      end
   end

   logic [11:0] mq_x, mq_y;
   logic [12:0] mv_x, mv_y;

   assign mq_x = slow_ff ? {1'b0, pc_x_ff[30:20]} : pc_x_ff[30:19];
   assign mq_y = slow_ff ? {1'b0, pc_y_ff[30:20]} : pc_y_ff[30:19];
   // output is the negated motion
   assign mv_x = dx_ff[7] ? {1'b0, mq_x} : 13'(-{1'b0, mq_x});
   assign mv_y = dy_ff[7] ? {1'b0, mq_y} : 13'(-{1'b0, mq_y});

   // wheel steps, a move of 2 or more that rounds to zero gives one step
   logic [2:0]  hq;
   logic [3:0]  vq;
   logic [12:0] hmag, vmag, hwheel, wheel;

   assign hq     = absx[7:5];
   assign vq     = absy[7:4];
   assign hmag   = !movx ? 13'd0 : (hq == 3'd0) ? 13'd1 : {10'd0, hq};
   assign vmag   = !movy ? 13'd0 : (vq == 4'd0) ? 13'd1 : {9'd0, vq};
   assign hwheel = dx_ff[7] ? hmag : 13'(-hmag);
   assign wheel  = dy_ff[7] ? 13'(-vmag) : vmag;

   // event list
   logic [2:0]  kind_ff [4];
   logic        press_ff [4];
   logic [12:0] val_ff [4];
   logic        sync_ff [4];
   logic [2:0]  n_ff;
   logic [1:0]  idx_ff;
   ev_kind_type kx, ky;
   logic [1:0]  yslot;

   assign kx    = dx_ff[7] ? EV_LEFT : EV_RIGHT;
   assign ky    = dy_ff[7] ? EV_UP : EV_DOWN;
   assign yslot = movx ? 2'd2 : 2'd0;

   always_ff @(posedge clock) begin
      if (cmd.commit && mode_arrow) begin
         // y key pair fills the slots from yslot upward
         for (int i = 0; i < 4; i++) begin
            press_ff[i] <= ~i[0];
            val_ff[i]   <= '0;
            sync_ff[i]  <= 1'b1;
            kind_ff[i]  <= (movy && (2'(i) >= yslot)) ? ky : kx;
         end
         n_ff <= {movx && movy, movx != movy, 1'b0};
      end else if (cmd.commit && mode_scroll) begin
         kind_ff[0]  <= EV_HWHEEL;
         press_ff[0] <= 1'b0;
         val_ff[0]   <= hwheel;
         sync_ff[0]  <= 1'b0;
         kind_ff[1]  <= EV_WHEEL;
         press_ff[1] <= 1'b0;
         val_ff[1]   <= wheel;
         sync_ff[1]  <= 1'b1;
         n_ff        <= 3'd2;
      end else if (cmd.fin) begin
         kind_ff[0]  <= EV_REL_X;
         press_ff[0] <= 1'b0;
         val_ff[0]   <= mv_x;
         sync_ff[0]  <= 1'b0;
         kind_ff[1]  <= EV_REL_Y;
         press_ff[1] <= 1'b0;
         val_ff[1]   <= mv_y;
         sync_ff[1]  <= 1'b1;
         n_ff        <= 3'd2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)            idx_ff <= '0;
      else if (cmd.commit)  idx_ff <= '0;
      else if (cmd.advance) idx_ff <= idx_ff + 2'd1;
   end

   // result payload
   assign rsp_tuser = kind_ff[idx_ff];
   assign rsp_tdata = {1'b0, sync_ff[idx_ff], val_ff[idx_ff], press_ff[idx_ff]};
   assign rsp_tlast = ({1'b0, idx_ff} == n_ff - 3'd1);

   // status
   always_comb begin
      stat.drop       = (wd_delay > {16'd0, wdog_ff}) || !ok_ff || (hdr_ff != HDR_MAGIC);
      stat.mouse      = !mode_arrow && !mode_scroll;
      stat.accel_need = accel_need;
      stat.key_none   = mode_arrow && !movx && !movy;
      stat.div_last   = (cnt_ff == 3'd0);
      stat.ev_final   = rsp_tlast;
   end

endmodule

`default_nettype wire

// ----- design/pointing_stick_motion_mapper.sv -----
// ----------------------------------------------------------------------------
// pointing_stick_motion_mapper
// turns pointing stick motion reports into key, wheel and relative events
//
//   channel | ports                               | carries
//   --------+-------------------------------------+-------------------------
//   req     | req_tvalid/tready/tdata             | one motion report
//   rsp     | rsp_tvalid/tready/tdata/tuser/tlast | one event, up to 4 each
//   csr     | csr_valid/ready/index/data          | register write
//
// a report is checked in the cycle after its transfer; arrow and scroll
// reports then present events at once; mouse reports first pass the speed
// division when acceleration applies, then states MUL_A, MUL_B, MUL_C, FIN.
// one report is in flight at a time; the event list waits on rsp_tready.
// synchronous reset restores register defaults and clears the service time.
// ----------------------------------------------------------------------------
`default_nettype none

module pointing_stick_motion_mapper (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // header_byte, delta_x, delta_y, bus_ok, irq_time_ms, now_ms, arrow_held,
   // scroll_held, slow_held, caps_lock, brightness
   input  wire  [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // key_pressed, rel_value, sync
   output logic [15:0]  rsp_tdata,
   // event_kind
   output logic [2:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire          csr_index,
   input  wire  [15:0]  csr_data
);
   import psmm_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   psmm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   psmm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule

`default_nettype wire
